@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the Josephus order selector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JOS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("josephus block assertion failed");
`define JOS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("josephus block assertion failed");
`else
`define JOS_ASSERT(lbl, clk, rst_n, prop)
`define JOS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/jos_pkg.sv @@
// ----------------------------------------------------------------------------
// jos_pkg
// Types, constants and helper functions of the Josephus order selector.
// ----------------------------------------------------------------------------
package jos_pkg;

	localparam int CNT_W      = 11;
	localparam int POS_W      = 10;
	localparam int SKIP_W     = 32;
	localparam int DVD_W      = 33;
	localparam int NODE_W     = 11;
	localparam int TREE_DEPTH = 2048;
	localparam int DIV_STEPS  = 33;
	localparam int STEP_W     = 6;
	localparam int REG_IDX_W  = 1;

	localparam logic [CNT_W-1:0] MAX_LEAVES = 11'd1024;

	localparam logic [REG_IDX_W-1:0] REG_PEOPLE_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SKIP_COUNT   = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BUILD,
		S_MOD_START,
		S_MOD_WAIT,
		S_DESC_INIT,
		S_DESC_RD,
		S_DESC_DEC,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic rebuild;
		logic build_step;
		logic mod_start;
		logic desc_init;
		logic desc_dec;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic build_last;
		logic mod_done;
		logic at_leaf;
	} dp_status_t;

	function automatic logic [CNT_W-1:0] clamp_people(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 11'd1;
		end else if (v > MAX_LEAVES) begin
			r = MAX_LEAVES;
		end
		return r;
	endfunction

	// Smallest power of two that is not below n, for n of at least one.
	function automatic logic [CNT_W-1:0] leaf_size(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] m;
		m = n - 11'd1;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		return m + 11'd1;
	endfunction

endpackage

@@ rtl/jos_divu.sv @@
// ----------------------------------------------------------------------------
// jos_divu
// Restoring remainder unit: one dividend bit per cycle, all 33 dividend bits per result.
// ----------------------------------------------------------------------------
module jos_divu import jos_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [CNT_W-1:0] remainder,
	output logic             done
);

	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;
	logic [CNT_W-1:0]  rem_nxt;

	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign diff    = trial - {1'b0, div_q};
	assign fits    = trial >= {1'b0, div_q};
	assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= rem_nxt;
				dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
				step_q <= step_q + 6'd1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign remainder = rem_q;
	assign done      = done_q;

endmodule

@@ rtl/jos_dp.sv @@
// ----------------------------------------------------------------------------
// jos_dp
// Datapath: configuration registers, count tree memory, rebuild sweep,
// remainder unit and the select-and-delete descent.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jos_dp import jos_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SKIP_W-1:0]    cfg_wdata,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic                 done,
	output logic [CNT_W-1:0]     removed_person,
	output logic                 round_done
);

	logic [CNT_W-1:0]  people_count_q;
	logic [SKIP_W-1:0] skip_count_q;
	logic [CNT_W-1:0]  people_left_q;
	logic [POS_W-1:0]  start_q;
	logic [CNT_W-1:0]  leaf_base_q;
	logic [CNT_W-1:0]  bn_q;
	logic [CNT_W-1:0]  bspan_q;
	logic [CNT_W-1:0]  boff_q;
	logic [NODE_W-1:0] bnode_q;
	logic [NODE_W-1:0] node_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  target_q;
	logic [POS_W-1:0]  pick_q;
	logic              done_q;
	logic [CNT_W-1:0]  removed_q;
	logic              round_done_q;

	logic [CNT_W-1:0]  tree_mem [TREE_DEPTH];
	logic [CNT_W-1:0]  rdata_q;
	logic [NODE_W-1:0] mem_raddr;
	logic [NODE_W-1:0] mem_waddr;
	logic [CNT_W-1:0]  mem_wdata;
	logic              mem_we;

	logic [CNT_W-1:0]  n_clamped;
	logic [CNT_W-1:0]  build_rest;
	logic [CNT_W-1:0]  build_cnt;
	logic [CNT_W-1:0]  boff_nxt;
	logic              go_left;
	logic [NODE_W-1:0] next_node;
	logic [CNT_W-1:0]  next_cnt;
	logic [CNT_W-1:0]  next_target;
	logic [DVD_W-1:0]  mod_dividend;
	logic [CNT_W-1:0]  mod_rem;
	logic              mod_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			people_count_q <= 11'd1;
			skip_count_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEOPLE_COUNT: people_count_q <= cfg_wdata[CNT_W-1:0];
				REG_SKIP_COUNT:   skip_count_q   <= cfg_wdata;
				default:          people_count_q <= people_count_q;
			endcase
		end
	end

	assign n_clamped  = clamp_people(people_count_q);
	assign build_rest = bn_q - boff_q;
	assign build_cnt  = (bn_q > boff_q) ? ((build_rest < bspan_q) ? build_rest : bspan_q) : '0;
	assign boff_nxt   = boff_q + bspan_q;

	assign go_left     = rdata_q >= target_q;
	assign next_node   = {node_q[NODE_W-2:0], ~go_left};
	assign next_cnt    = go_left ? rdata_q : cnt_q - rdata_q;
	assign next_target = go_left ? target_q : target_q - rdata_q;

	assign mod_dividend = DVD_W'(start_q) + DVD_W'(skip_count_q);

	jos_divu u_divu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (mod_dividend),
		.divisor   (people_left_q),
		.remainder (mod_rem),
		.done      (mod_done)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bnode_q;
		mem_wdata = build_cnt;
		if (cmd.build_step) begin
			mem_we = 1'b1;
		end else if (cmd.desc_init) begin
			mem_we    = 1'b1;
			mem_waddr = 11'd1;
			mem_wdata = people_left_q - 11'd1;
		end else if (cmd.desc_dec) begin
			mem_we    = 1'b1;
			mem_waddr = next_node;
			mem_wdata = next_cnt - 11'd1;
		end
	end

	assign mem_raddr = {node_q[NODE_W-2:0], 1'b0};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= tree_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			people_left_q <= '0;
			start_q       <= '0;
			leaf_base_q   <= 11'd1;
			bn_q          <= 11'd1;
			bspan_q       <= 11'd1;
			boff_q        <= '0;
			bnode_q       <= 11'd1;
			node_q        <= 11'd1;
			cnt_q         <= '0;
			target_q      <= '0;
			pick_q        <= '0;
			done_q        <= 1'b0;
			removed_q     <= '0;
			round_done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.accept && cmd.rebuild) begin
				bn_q          <= n_clamped;
				leaf_base_q   <= leaf_size(n_clamped);
				bspan_q       <= leaf_size(n_clamped);
				boff_q        <= '0;
				bnode_q       <= 11'd1;
				people_left_q <= n_clamped;
				start_q       <= '0;
			end
			if (cmd.build_step) begin
				bnode_q <= bnode_q + 11'd1;
				if (boff_nxt == leaf_base_q) begin
					bspan_q <= bspan_q >> 1;
					boff_q  <= '0;
				end else begin
					boff_q <= boff_nxt;
				end
			end
			if (cmd.desc_init) begin
				pick_q   <= mod_rem[POS_W-1:0];
				target_q <= mod_rem + 11'd1;
				node_q   <= 11'd1;
				cnt_q    <= people_left_q;
			end
			if (cmd.desc_dec) begin
				node_q   <= next_node;
				cnt_q    <= next_cnt;
				target_q <= next_target;
			end
			if (cmd.finish) begin
				people_left_q <= people_left_q - 11'd1;
				start_q       <= pick_q;
				done_q        <= 1'b1;
				removed_q     <= node_q - leaf_base_q + 11'd1;
				round_done_q  <= people_left_q == 11'd1;
			end
		end
	end

	assign status.empty      = people_left_q == '0;
	assign status.build_last = (bspan_q == 11'd1) && (boff_q == leaf_base_q - 11'd1);
	assign status.mod_done   = mod_done;
	assign status.at_leaf    = node_q >= leaf_base_q;

	assign done           = done_q;
	assign removed_person = removed_q;
	assign round_done     = round_done_q;

	`JOS_ASSERT(a_desc_target, clk, arst_n, cmd.desc_dec |-> (target_q != '0 && target_q <= cnt_q))
	`JOS_ASSERT(a_label_range, clk, arst_n, done_q |-> (removed_q != '0 && removed_q <= leaf_base_q))
	`JOS_ASSERT(a_finish_left, clk, arst_n, cmd.finish |-> people_left_q != '0)

endmodule

@@ rtl/jos_ctrl.sv @@
// ----------------------------------------------------------------------------
// jos_ctrl
// Controller: sequences the rebuild (when needed), remainder, descent and result for one beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jos_ctrl import jos_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       restart,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = (restart || status.empty) ? S_BUILD : S_MOD_START;
				end
			end
			S_BUILD: begin
				if (status.build_last) begin
					state_nxt = S_MOD_START;
				end
			end
			S_MOD_START: state_nxt = S_MOD_WAIT;
			S_MOD_WAIT: begin
				if (status.mod_done) begin
					state_nxt = S_DESC_INIT;
				end
			end
			S_DESC_INIT: state_nxt = S_DESC_RD;
			S_DESC_RD:   state_nxt = status.at_leaf ? S_FINISH : S_DESC_DEC;
			S_DESC_DEC:  state_nxt = S_DESC_RD;
			S_FINISH:    state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.rebuild = restart || status.empty;
		case (state_q)
			S_IDLE:      cmd.accept     = start;
			S_BUILD:     cmd.build_step = 1'b1;
			S_MOD_START: cmd.mod_start  = 1'b1;
			S_DESC_INIT: cmd.desc_init  = 1'b1;
			S_DESC_DEC:  cmd.desc_dec   = 1'b1;
			S_FINISH:    cmd.finish     = 1'b1;
			default:     cmd.accept     = 1'b0;
		endcase
	end

	assign busy = state_q != S_IDLE;

	`JOS_ASSERT(a_mod_done_wait, clk, arst_n, status.mod_done |-> state_q == S_MOD_WAIT)
	`JOS_ASSERT(a_dec_after_rd, clk, arst_n, state_q == S_DESC_DEC |-> $past(state_q) == S_DESC_RD)
	`JOS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !busy)

endmodule

@@ rtl/josephus_order_select_delete.sv @@
// ----------------------------------------------------------------------------
// josephus_order_select_delete
// Josephus elimination order from an order-statistics count tree.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; each beat gives exactly
// one result, shown for a single cycle with done high, and the receiver cannot
// hold it off. From acceptance a beat runs the one-bit-per-cycle remainder
// unit, then for each tree level the registered read and the decrement of the
// count memory, then the result. A beat that restarts the circle, is the first
// after reset, or follows a finished round first sweeps the tree.
module josephus_order_select_delete import jos_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [SKIP_W-1:0]    cfg_wdata,
	input  logic                 start,
	input  logic                 restart,
	output logic                 busy,
	output logic                 done,
	output logic [CNT_W-1:0]     removed_person,
	output logic                 round_done
);

	dp_cmd_t    cmd;
	dp_status_t status;

	jos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.restart (restart),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	jos_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.status         (status),
		.done           (done),
		.removed_person (removed_person),
		.round_done     (round_done)
	);

endmodule

@@ sim/josephus_order_select_delete_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_order_select_delete_test
// Self-checking bench for the Josephus elimination order block. Register
// writes and removal beats come from one queue. Each beat is predicted with
// a private count tree, and every strobed result is compared in order.
// ----------------------------------------------------------------------------
module josephus_order_select_delete_test;
	import jos_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 5_000_000;
	localparam int unsigned DRAIN_CYCLES = 2200;

	typedef struct {
		bit                   is_write;
		logic [REG_IDX_W-1:0] index;
		logic [SKIP_W-1:0]    data;
		logic                 restart_bit;
	} circle_op_t;

	typedef struct {
		logic [CNT_W-1:0] person;
		logic             last;
	} removal_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_PEOPLE_COUNT;
	logic [SKIP_W-1:0]    cfg_wdata = '0;
	logic                 start     = 1'b0;
	logic                 restart   = 1'b0;
	logic                 busy;
	logic                 done;
	logic [CNT_W-1:0]     removed_person;
	logic                 round_done;

	circle_op_t  circle_ops[$];
	removal_t    removals_due[$];
	int unsigned beats_sent     = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	logic [CNT_W-1:0]  people_cfg = 11'd1;
	logic [SKIP_W-1:0] skip_cfg   = '0;
	int unsigned       count_tree[0:2047];
	int unsigned       leaf_span  = 1;
	logic [POS_W-1:0]  rank_base  = '0;
	logic [CNT_W-1:0]  survivors  = '0;

	josephus_order_select_delete i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.start          (start),
		.restart        (restart),
		.busy           (busy),
		.done           (done),
		.removed_person (removed_person),
		.round_done     (round_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		foreach (count_tree[i]) begin
			count_tree[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void queue_step(input logic r);
		circle_op_t op;
		op.is_write    = 1'b0;
		op.index       = REG_PEOPLE_COUNT;
		op.data        = '0;
		op.restart_bit = r;
		circle_ops.push_back(op);
	endfunction

	function automatic void queue_write(input logic [REG_IDX_W-1:0] idx,
			input logic [SKIP_W-1:0] wd);
		circle_op_t op;
		op.is_write    = 1'b1;
		op.index       = idx;
		op.data        = wd;
		op.restart_bit = 1'b0;
		circle_ops.push_back(op);
	endfunction

	function automatic void apply_write(input logic [REG_IDX_W-1:0] idx,
			input logic [SKIP_W-1:0] wd);
		if (idx == REG_PEOPLE_COUNT) begin
			people_cfg = wd[CNT_W-1:0];
		end else if (idx == REG_SKIP_COUNT) begin
			skip_cfg = wd;
		end
	endfunction

	function automatic void rebuild_circle();
		int unsigned n;
		int unsigned w;
		int unsigned k;
		n = 32'(people_cfg);
		if (n == 0) begin
			n = 1;
		end else if (n > int'(MAX_LEAVES)) begin
			n = 32'(MAX_LEAVES);
		end
		w = 1;
		while (w < n) begin
			w = w * 2;
		end
		foreach (count_tree[i]) begin
			count_tree[i] = 0;
		end
		for (k = 0; k < n; k++) begin
			count_tree[w + k] = 1;
		end
		for (k = w - 1; k >= 1; k--) begin
			count_tree[k] = count_tree[2 * k] + count_tree[2 * k + 1];
		end
		leaf_span = w;
		survivors = CNT_W'(n);
		rank_base = '0;
	endfunction

	function automatic void predict_removal(input logic r);
		logic [63:0] pick;
		int unsigned target;
		int unsigned node;
		removal_t    res;
		if (r || survivors == 0) begin
			rebuild_circle();
		end
		pick = (64'(rank_base) + 64'(skip_cfg)) % 64'(survivors);
		target = int'(pick) + 1;
		node = 1;
		if (count_tree[node] > 0) begin
			count_tree[node]--;
		end
		while (node < leaf_span) begin
			if (count_tree[2 * node] >= target) begin
				node = 2 * node;
			end else begin
				target = target - count_tree[2 * node];
				node = 2 * node + 1;
			end
			if (count_tree[node] > 0) begin
				count_tree[node]--;
			end
		end
		survivors = survivors - 1'b1;
		rank_base = pick[POS_W-1:0];
		res.person = CNT_W'(node - leaf_span + 1);
		res.last = (survivors == 0);
		removals_due.push_back(res);
	endfunction

	always @(posedge clk or negedge arst_n) begin : feed_proc
		logic                 go;
		logic                 rs;
		logic                 we;
		logic [REG_IDX_W-1:0] idx;
		logic [SKIP_W-1:0]    wd;
		int unsigned          idle_pct;
		circle_op_t           op;
		if (!arst_n) begin
			start     <= 1'b0;
			restart   <= 1'b0;
			cfg_we    <= 1'b0;
			cfg_index <= REG_PEOPLE_COUNT;
			cfg_wdata <= '0;
		end else begin
			go  = start;
			rs  = restart;
			we  = 1'b0;
			idx = cfg_index;
			wd  = cfg_wdata;
			idle_pct = (beats_sent >= 150 && beats_sent < 260) ? 0 : 18;
			if (start && !busy) begin
				predict_removal(restart);
				beats_sent++;
				go = 1'b0;
			end
			if (!go && circle_ops.size() != 0) begin
				op = circle_ops[0];
				if (op.is_write) begin
					if (removals_due.size() == 0 && !busy) begin
						we  = 1'b1;
						idx = op.index;
						wd  = op.data;
						apply_write(op.index, op.data);
						void'(circle_ops.pop_front());
					end
				end else if (!cfg_we && $urandom_range(99) >= idle_pct) begin
					go = 1'b1;
					rs = op.restart_bit;
					void'(circle_ops.pop_front());
				end
			end
			start     <= go;
			restart   <= rs;
			cfg_we    <= we;
			cfg_index <= idx;
			cfg_wdata <= wd;
		end
	end

	always @(posedge clk) begin : check_proc
		removal_t want;
		if (arst_n && done) begin
			if (removals_due.size() == 0) begin
				$display("%0t: result with none due, person %0d round_done %0b",
					$time, removed_person, round_done);
				mismatch_count++;
			end else begin
				want = removals_due.pop_front();
				if (removed_person !== want.person) begin
					$display("%0t: removed_person expected %0d actual %0d",
						$time, want.person, removed_person);
					mismatch_count++;
				end
				if (round_done !== want.last) begin
					$display("%0t: round_done expected %0b actual %0b",
						$time, want.last, round_done);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog_proc
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("josephus_order_select_delete regression: fail");
		$finish;
	end

	initial begin : stimulus_proc
		int unsigned       n;
		int unsigned       live;
		int unsigned       steps;
		int unsigned       which;
		int unsigned       random_beats;
		logic [SKIP_W-1:0] wd;

		// Reset values: one person, no skip.
		queue_step(1'b0);
		queue_write(REG_PEOPLE_COUNT, 32'd0);
		queue_write(REG_SKIP_COUNT, 32'hFFFF_FFFF);
		queue_step(1'b0);
		queue_step(1'b1);
		queue_write(REG_PEOPLE_COUNT, 32'd5);
		queue_write(REG_SKIP_COUNT, 32'd0);
		repeat (6) queue_step(1'b0);
		queue_write(REG_PEOPLE_COUNT, 32'd7);
		queue_write(REG_SKIP_COUNT, 32'hFFFF_FFFF);
		queue_step(1'b1);
		repeat (2) queue_step(1'b0);
		// The new count must wait for the next rebuild.
		queue_write(REG_PEOPLE_COUNT, 32'd3);
		repeat (4) queue_step(1'b0);
		queue_step(1'b1);
		queue_write(REG_PEOPLE_COUNT, 32'hFFFF_FFFF);
		queue_write(REG_SKIP_COUNT, 32'd1023);
		queue_step(1'b1);
		repeat (2) queue_step(1'b0);
		queue_write(REG_PEOPLE_COUNT, 32'd1024);
		queue_step(1'b1);
		queue_step(1'b0);

		random_beats = 0;
		while (random_beats < 500) begin
			which = $urandom_range(99);
			if (which < 5) begin
				n = $urandom_range(512, 2047);
			end else if (which < 10) begin
				n = $urandom_range(0, 1);
			end else begin
				n = $urandom_range(1, 40);
			end
			live = (n == 0) ? 1 : ((n > 1024) ? 1024 : n);
			which = $urandom_range(2);
			if (which != 2) begin
				wd = $urandom;
				wd[CNT_W-1:0] = CNT_W'(n);
				queue_write(REG_PEOPLE_COUNT, wd);
			end
			if (which != 1) begin
				case ($urandom_range(3))
					0: wd = $urandom_range(0, 12);
					1: wd = $urandom;
					2: wd = 32'hFFFF_FFFF - $urandom_range(0, 8);
					default: wd = $urandom_range(0, 64);
				endcase
				queue_write(REG_SKIP_COUNT, wd);
			end
			if (live > 64) begin
				steps = $urandom_range(5, 30);
			end else begin
				steps = $urandom_range(1, 2 * live + 2);
			end
			repeat (steps) begin
				queue_step($urandom_range(99) < 10);
			end
			random_beats += steps;
		end

		while (circle_ops.size() != 0 || start || removals_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("josephus_order_select_delete regression: pass");
		end else begin
			$display("josephus_order_select_delete regression: fail");
		end
		$finish;
	end

endmodule
